// File: rtl/core/wsps_pkg.sv
`timescale 1ns / 1ps
// Package for the weighted sequence packet scheduler.
// Holds sizes, slot layout, command and register codes; no dependencies.
package wsps_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int TYPE_COUNT = 8;
    localparam int POS_W      = 3;
    localparam int LEN_W      = 4;
    localparam int TYPE_W     = 3;
    localparam int COUNT_W    = 8;
    localparam int SLOT_W     = 12;
    localparam int HALF_W     = 48;
    localparam int TDATA_W    = 8;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [0:0] {
        CMD_ENQUEUE  = 1'b0,
        CMD_TRANSMIT = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOTS_LO = 2'd0,
        REG_SLOTS_HI = 2'd1,
        REG_SEQ_LEN  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic               allow_pending;
        logic [COUNT_W-1:0] count;
        logic [TYPE_W-1:0]  ptype;
    } slot_t;

endpackage

// File: rtl/core/weighted_sequence_packet_scheduler_top.sv
`timescale 1ns / 1ps
// Top level of the weighted sequence packet scheduler.
// Depends on wsps_pkg for sizes, slot layout and codes.
//
//  channel  | direction | signals                               | beat
//  ---------+-----------+---------------------------------------+-----------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tuser     | enqueue or transmit
//  m_*      | out       | m_tvalid m_tready m_tdata m_tuser     | one per transmit
//  cfg_*    | in        | cfg_valid cfg_ready cfg_index cfg_data| register write
//
// One beat per cycle unless a stalled result register holds a transmit beat: a beat lands
// in the input register, then the slot lookup, priority encode and counter update run, and
// a transmit beat loads the result register while an enqueue beat marks its type pending.
// Reset clears pending types, slot position, repeat counter and the slot table;
// sequence length resets to one. cfg_ready is always high.
// A stalled result register holds a transmit beat back in the input register.
module weighted_sequence_packet_scheduler_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wsps_pkg::TDATA_W-1:0]      s_tdata,   // [2:0] packet_type
    input  logic                              s_tuser,   // [0] command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wsps_pkg::TDATA_W-1:0]      m_tdata,   // [2:0] chosen_type
    output logic                              m_tuser,   // [0] from_pending
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wsps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wsps_pkg::HALF_W-1:0]       cfg_data
);
    import wsps_pkg::*;

    logic [HALF_W-1:0]     slots_lo_reg;
    logic [HALF_W-1:0]     slots_hi_reg;
    logic [LEN_W-1:0]      seq_len_reg;

    logic                  in_valid_reg;
    cmd_t                  in_cmd_reg;
    logic [TYPE_W-1:0]     in_type_reg;

    logic                  out_valid_reg;
    logic [TYPE_W-1:0]     out_type_reg;
    logic                  out_pend_reg;

    logic [TYPE_COUNT-1:0] pending_reg;
    logic [TYPE_COUNT-1:0] pending_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [COUNT_W-1:0]    rpt_reg;
    logic [COUNT_W-1:0]    rpt_next;

    logic                  advance;
    logic                  is_xmit;
    logic [LEN_W-1:0]      len_eff;
    logic [POS_W-1:0]      pos_cur;
    logic [LEN_W-1:0]      pos_inc;
    logic [2*HALF_W-1:0]   slot_vec;
    slot_t                 slot;
    logic [COUNT_W-1:0]    count_eff;
    logic [COUNT_W-1:0]    rpt_inc;
    logic                  take_pend;
    logic [TYPE_W-1:0]     low_pend;
    logic [TYPE_W-1:0]     chosen;

    assign is_xmit   = (in_cmd_reg == CMD_TRANSMIT);
    assign advance   = in_valid_reg && (!is_xmit || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(TDATA_W-TYPE_W){1'b0}}, out_type_reg};
    assign m_tuser   = out_pend_reg;

    always_comb
    begin
        len_eff = seq_len_reg;
        if (seq_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (seq_len_reg > LEN_W'(SLOT_COUNT))
        begin
            len_eff = LEN_W'(SLOT_COUNT);
        end
    end

    // Fall back to slot zero when the length was lowered under the position.
    assign pos_cur   = ({1'b0, pos_reg} >= len_eff) ? '0 : pos_reg;
    assign slot_vec  = {slots_hi_reg, slots_lo_reg};
    assign slot      = slot_t'(slot_vec[pos_cur*SLOT_W +: SLOT_W]);
    assign count_eff = (slot.count == '0) ? COUNT_W'(1) : slot.count;
    assign rpt_inc   = rpt_reg + COUNT_W'(1);
    assign pos_inc   = {1'b0, pos_cur} + LEN_W'(1);
    assign take_pend = slot.allow_pending && (pending_reg != '0);

    always_comb
    begin
        low_pend = '0;
        for (int t = TYPE_COUNT - 1; t >= 0; t--)
        begin
            if (pending_reg[t])
            begin
                low_pend = TYPE_W'(t);
            end
        end
    end

    assign chosen = take_pend ? low_pend : slot.ptype;

    always_comb
    begin
        pending_next = pending_reg;
        pos_next     = pos_reg;
        rpt_next     = rpt_reg;
        if (advance)
        begin
            if (!is_xmit)
            begin
                if (32'(in_type_reg) < TYPE_COUNT)
                begin
                    pending_next[in_type_reg] = 1'b1;
                end
            end
            else
            begin
                if (take_pend)
                begin
                    pending_next[low_pend] = 1'b0;
                end
                // Move on once the repeat count is reached or the counter wraps.
                if ((rpt_inc >= count_eff) || (rpt_inc == '0))
                begin
                    rpt_next = '0;
                    pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
                end
                else
                begin
                    rpt_next = rpt_inc;
                    pos_next = pos_cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_lo_reg  <= '0;
            slots_hi_reg  <= '0;
            seq_len_reg   <= LEN_W'(1);
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
            pos_reg       <= '0;
            rpt_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SLOTS_LO: slots_lo_reg <= cfg_data;
                    REG_SLOTS_HI: slots_hi_reg <= cfg_data;
                    REG_SEQ_LEN:  seq_len_reg  <= cfg_data[LEN_W-1:0];
                    default:      ;
                endcase
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && is_xmit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            pending_reg <= pending_next;
            pos_reg     <= pos_next;
            rpt_reg     <= rpt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= cmd_t'(s_tuser);
            in_type_reg <= s_tdata[TYPE_W-1:0];
        end
        if (advance && is_xmit)
        begin
            out_type_reg <= chosen;
            out_pend_reg <= take_pend;
        end
    end

    a_xmit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_xmit |=> out_valid_reg)
        else $error("transmit beat did not load the result register");

    a_pending_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_xmit && take_pend |=> !pending_reg[$past(low_pend)])
        else $error("pending type still set after being sent");

    a_enqueue_sets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_xmit |=> pending_reg[$past(in_type_reg)])
        else $error("enqueued type not marked pending");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_type_reg))
        else $error("stalled beat lost from the input register");

endmodule
